### rtl/core/rfor_pkg.sv
package rfor_pkg;

    // Canvas geometry
    localparam int MAX_SIDE  = 256;
    localparam int FRAC_BITS = 8;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int ADDR_W    = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CFG_W     = 9;
    localparam int COORD_W   = 24;
    localparam int CHAR_W    = 8;
    // Room for l + w - one and for a pixel position col << FRAC_BITS
    localparam int GEO_W     = COORD_W + SIDE_W + FRAC_BITS + 2;
    localparam int ONE_FX    = 1 << FRAC_BITS;

    localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h52;
    localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;

    localparam logic [CFG_W-1:0]  RESET_WIDTH  = CFG_W'(MAX_SIDE);
    localparam logic [CFG_W-1:0]  RESET_HEIGHT = CFG_W'(MAX_SIDE);
    localparam logic [CHAR_W-1:0] RESET_BG     = 8'h20;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } rfor_func_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BG     = 2'd2,
        CFG_NONE   = 2'd3
    } rfor_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_RDWAIT,
        ST_DONE
    } rfor_state_t;

    typedef struct packed {
        rfor_func_t                 func;
        logic signed [COORD_W-1:0]  rect_left;
        logic signed [COORD_W-1:0]  rect_top;
        logic signed [COORD_W-1:0]  rect_span_x;
        logic signed [COORD_W-1:0]  rect_span_y;
        logic [CHAR_W-1:0]          shape_letter;
        logic [CHAR_W-1:0]          paint_char;
        logic [SIDE_W-1:0]          read_col;
        logic [SIDE_W-1:0]          read_row;
    } rfor_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_char;
        logic              error_flag;
    } rfor_res_t;

    // Clamped canvas size and background byte
    typedef struct packed {
        logic [CFG_W-1:0]  side_w;
        logic [CFG_W-1:0]  side_h;
        logic [CHAR_W-1:0] bg;
    } rfor_cfg_t;

    // Sequencer status toward the channel logic
    typedef struct packed {
        logic      idle;
        logic      res_valid;
        rfor_res_t res;
    } rfor_stat_t;

endpackage

### rtl/core/rectangle_fill_outline_rasterizer.sv
// Channel | Direction | Handshake           | Payload
// cmd     | in        | cmd_valid/cmd_stall | cmd_data  (rfor_cmd_t)
// res     | out       | res_valid/res_stall | res_data  (rfor_res_t)
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// Clear and a legal draw scan the whole canvas row by row, one canvas pixel
// per cycle, through the single write port of the canvas RAM: clear writes
// every pixel, draw only the painted ones. Read uses the registered RAM read;
// a rejected or ignored draw and the unused code skip the scan.
// Reset clears control state only; the canvas holds no value until cleared.
// A stalled result waits in the output register while the next request runs.
module rectangle_fill_outline_rasterizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  rfor_pkg::rfor_cmd_t cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output rfor_pkg::rfor_res_t res_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_wdata
);
    import rfor_pkg::*;

    logic [CFG_W-1:0]  width_reg, width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic [CHAR_W-1:0] bg_reg, bg_next;
    logic              res_valid_reg, res_valid_next;
    rfor_res_t         res_data_reg, res_data_next;

    rfor_cfg_t  cfg;
    rfor_stat_t stat;
    logic       cmd_accept;
    logic       out_free;
    logic       res_load;

    function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            clamp_side = CFG_W'(1);
        end
        else if (v > CFG_W'(MAX_SIDE))
        begin
            clamp_side = CFG_W'(MAX_SIDE);
        end
        else
        begin
            clamp_side = v;
        end
    endfunction

    assign cfg_ready = 1'b1;

    // Register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        bg_next     = bg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (rfor_cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_next  = cfg_wdata;
                CFG_HEIGHT: height_next = cfg_wdata;
                CFG_BG:     bg_next     = cfg_wdata[CHAR_W-1:0];
                CFG_NONE:   bg_next     = bg_reg;
            endcase
        end
    end

    assign cfg.side_w = clamp_side(width_reg);
    assign cfg.side_h = clamp_side(height_reg);
    assign cfg.bg     = bg_reg;

    // Accept a request only while the sequencer is free
    assign cmd_stall  = !stat.idle;
    assign cmd_accept = cmd_valid && !cmd_stall;

    // Output register; load when empty or being drained
    assign out_free = !res_valid_reg || !res_stall;
    assign res_load = stat.res_valid && out_free;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_data_next  = stat.res;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            bg_reg        <= RESET_BG;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            bg_reg        <= bg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    rfor_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_accept),
        .cmd      (cmd_data),
        .cfg      (cfg),
        .out_free (out_free),
        .stat     (stat)
    );

    // An accepted request keeps the sequencer busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> !stat.idle)
        else $error("sequencer idle after accepting a request");

    // A finished result lands in the output register
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (res_valid && res_data == $past(stat.res)))
        else $error("finished result not loaded");

    // A new result only comes from the sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(stat.res_valid))
        else $error("result appeared without a finished request");

endmodule

### rtl/core/rfor_ram.sv
module rfor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rfor_ctrl.sv
module rfor_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rfor_pkg::rfor_cmd_t cmd,
    input  rfor_pkg::rfor_cfg_t cfg,
    input  logic                out_free,
    output rfor_pkg::rfor_stat_t stat
);
    import rfor_pkg::*;

    rfor_state_t state_reg, state_next;

    rfor_cmd_t cmd_reg, cmd_next;
    logic [SIDE_W-1:0] col_reg, col_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic err_reg, err_next;
    logic [CHAR_W-1:0] pix_reg, pix_next;

    logic signed [GEO_W-1:0] left_reg, left_next, right_reg, right_next;
    logic signed [GEO_W-1:0] left1_reg, left1_next, right1_reg, right1_next;
    logic signed [GEO_W-1:0] top_reg, top_next, bot_reg, bot_next;
    logic signed [GEO_W-1:0] top1_reg, top1_next, bot1_reg, bot1_next;

    logic signed [GEO_W-1:0] one_fx;
    logic signed [GEO_W-1:0] px, py;
    logic draw_ok;
    logic col_last, row_last, scan_last;
    logic x_in, y_in, x_edge, y_edge, in_rect, border, paint;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [SIDE_W-1:0] row,
                                                   input logic [SIDE_W-1:0] col);
        pix_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col));
    endfunction

    assign one_fx = signed'(GEO_W'(ONE_FX));

    // Draw is legal only for positive spans and a known shape letter
    assign draw_ok = (cmd_reg.rect_span_x > 0) && (cmd_reg.rect_span_y > 0) &&
                     ((cmd_reg.shape_letter == SHAPE_FILLED) ||
                      (cmd_reg.shape_letter == SHAPE_OUTLINE));

    // Scan position in fixed point
    assign px = signed'(GEO_W'(col_reg) << FRAC_BITS);
    assign py = signed'(GEO_W'(row_reg) << FRAC_BITS);

    assign col_last  = (col_reg == SIDE_W'(cfg.side_w - CFG_W'(1)));
    assign row_last  = (row_reg == SIDE_W'(cfg.side_h - CFG_W'(1)));
    assign scan_last = col_last && row_last;

    // Classify the current pixel against the closed rectangle
    assign x_in    = (px >= left_reg) && (px <= right_reg);
    assign y_in    = (py >= top_reg) && (py <= bot_reg);
    assign x_edge  = (px < left1_reg) || (px > right1_reg);
    assign y_edge  = (py < top1_reg) || (py > bot1_reg);
    assign in_rect = x_in && y_in;
    assign border  = in_rect && (x_edge || y_edge);
    assign paint   = border || (in_rect && (cmd_reg.shape_letter == SHAPE_FILLED));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                unique case (cmd_reg.func)
                    FUNC_CLEAR: state_next = ST_SCAN;
                    FUNC_DRAW:  state_next = (!err_reg && draw_ok) ? ST_SCAN : ST_DONE;
                    FUNC_READ:  state_next = ST_RDWAIT;
                    FUNC_NOP:   state_next = ST_DONE;
                endcase
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ram_we         = 1'b0;
        stat.idle      = 1'b0;
        stat.res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:   stat.idle = 1'b1;
            ST_SETUP:  ram_we = 1'b0;
            ST_SCAN:   ram_we = (cmd_reg.func == FUNC_CLEAR) || paint;
            ST_RDWAIT: ram_we = 1'b0;
            ST_DONE:   stat.res_valid = 1'b1;
            default:   stat.idle = 1'b0;
        endcase
    end

    assign stat.res.pixel_char = pix_reg;
    assign stat.res.error_flag = err_reg;

    assign ram_waddr = pix_addr(row_reg, col_reg);
    assign ram_wdata = (cmd_reg.func == FUNC_CLEAR) ? cfg.bg : cmd_reg.paint_char;
    assign ram_raddr = pix_addr(cmd_reg.read_row, cmd_reg.read_col);

    // Datapath next values
    always_comb
    begin
        cmd_next    = cmd_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        err_next    = err_reg;
        pix_next    = pix_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        left1_next  = left1_reg;
        right1_next = right1_reg;
        top_next    = top_reg;
        bot_next    = bot_reg;
        top1_next   = top1_reg;
        bot1_next   = bot1_reg;

        // Capture the request
        if (state_reg == ST_IDLE && start)
        begin
            cmd_next = cmd;
        end

        // Precompute edges and settle the error flag for a bad draw
        if (state_reg == ST_SETUP)
        begin
            left_next   = GEO_W'(cmd_reg.rect_left);
            right_next  = GEO_W'(cmd_reg.rect_left) + GEO_W'(cmd_reg.rect_span_x);
            left1_next  = GEO_W'(cmd_reg.rect_left) + one_fx;
            right1_next = GEO_W'(cmd_reg.rect_left) + GEO_W'(cmd_reg.rect_span_x) - one_fx;
            top_next    = GEO_W'(cmd_reg.rect_top);
            bot_next    = GEO_W'(cmd_reg.rect_top) + GEO_W'(cmd_reg.rect_span_y);
            top1_next   = GEO_W'(cmd_reg.rect_top) + one_fx;
            bot1_next   = GEO_W'(cmd_reg.rect_top) + GEO_W'(cmd_reg.rect_span_y) - one_fx;
            pix_next    = '0;
            if (cmd_reg.func == FUNC_DRAW && !err_reg && !draw_ok)
            begin
                err_next = 1'b1;
            end
        end

        // Advance the scan, row by row
        if (state_reg == ST_SCAN)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + SIDE_W'(1);
            end
            else
            begin
                col_next = col_reg + SIDE_W'(1);
            end
            if (scan_last && cmd_reg.func == FUNC_CLEAR)
            begin
                err_next = 1'b0;
            end
        end

        // Take the read data, zero outside the canvas
        if (state_reg == ST_RDWAIT)
        begin
            if (CFG_W'(cmd_reg.read_col) < cfg.side_w &&
                CFG_W'(cmd_reg.read_row) < cfg.side_h)
            begin
                pix_next = ram_rdata;
            end
            else
            begin
                pix_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pix_reg    <= pix_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        left1_reg  <= left1_next;
        right1_reg <= right1_next;
        top_reg    <= top_next;
        bot_reg    <= bot_next;
        top1_reg   <= top1_next;
        bot1_reg   <= bot1_next;
    end

    rfor_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### tb/rectangle_fill_outline_rasterizer_tb.sv
module rectangle_fill_outline_rasterizer_tb;
    import rfor_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 1500;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 15;
    localparam int PRINT_CAP     = 100;

    typedef enum {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } flow_mode_t;

    // Canvas tracker: mirrors the pixel store, the sticky error and the
    // registers, and holds the results each accepted request must produce.
    class canvas_scoreboard;
        typedef enum {
            PIX_OUTSIDE,
            PIX_BORDER,
            PIX_INTERIOR
        } pixel_class_t;

        logic [CHAR_W-1:0] canvas_bytes [MAX_SIDE*MAX_SIDE];
        logic              sticky_error;
        logic [CFG_W-1:0]  width_reg;
        logic [CFG_W-1:0]  height_reg;
        logic [CHAR_W-1:0] bg_reg;
        rfor_res_t         expected_pixels [$];
        int                mismatches;

        function new();
            sticky_error = 1'b0;
            width_reg    = RESET_WIDTH;
            height_reg   = RESET_HEIGHT;
            bg_reg       = RESET_BG;
            mismatches   = 0;
        endfunction

        function void set_register(rfor_cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_WIDTH:  width_reg  = value;
                CFG_HEIGHT: height_reg = value;
                CFG_BG:     bg_reg     = value[CHAR_W-1:0];
                default:    ;
            endcase
        endfunction

        // Zero acts as one, anything above the store side as the full side
        function int clamp_side(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return int'(v);
        endfunction

        function int canvas_cols();
            return clamp_side(width_reg);
        endfunction

        function int canvas_rows();
            return clamp_side(height_reg);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Closed rectangle; border is inside and under one unit from an edge
        function pixel_class_t classify(longint px, longint py, longint l, longint t,
                                        longint w, longint h);
            longint r;
            longint b;
            r = l + w;
            b = t + h;
            if (px < l || px > r || py < t || py > b)
                return PIX_OUTSIDE;
            if (px - l < ONE_FX || r - px < ONE_FX || py - t < ONE_FX || b - py < ONE_FX)
                return PIX_BORDER;
            return PIX_INTERIOR;
        endfunction

        // Apply one request to the mirrored canvas and queue its result
        function void note_request(rfor_cmd_t c);
            rfor_res_t    want;
            int           cols;
            int           rows;
            longint       l;
            longint       t;
            longint       w;
            longint       h;
            pixel_class_t cls;
            cols = canvas_cols();
            rows = canvas_rows();
            l    = c.rect_left;
            t    = c.rect_top;
            w    = c.rect_span_x;
            h    = c.rect_span_y;
            want = '0;
            case (c.func)
                FUNC_CLEAR:
                begin
                    for (int row = 0; row < rows; row++)
                        for (int col = 0; col < cols; col++)
                            canvas_bytes[row*MAX_SIDE + col] = bg_reg;
                    sticky_error = 1'b0;
                end
                FUNC_DRAW:
                begin
                    if (!sticky_error)
                    begin
                        if (w <= 0 || h <= 0 ||
                            (c.shape_letter != SHAPE_FILLED &&
                             c.shape_letter != SHAPE_OUTLINE))
                            sticky_error = 1'b1;
                        else
                        begin
                            for (int row = 0; row < rows; row++)
                            begin
                                for (int col = 0; col < cols; col++)
                                begin
                                    cls = classify(longint'(col) << FRAC_BITS,
                                                   longint'(row) << FRAC_BITS, l, t, w, h);
                                    if (cls == PIX_BORDER ||
                                        (cls == PIX_INTERIOR && c.shape_letter == SHAPE_FILLED))
                                        canvas_bytes[row*MAX_SIDE + col] = c.paint_char;
                                end
                            end
                        end
                    end
                end
                FUNC_READ:
                begin
                    if (c.read_col < cols && c.read_row < rows)
                        want.pixel_char = canvas_bytes[c.read_row*MAX_SIDE + c.read_col];
                end
                default: ;
            endcase
            want.error_flag = sticky_error;
            expected_pixels.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one delivered result with the oldest queued one
        task check_result(rfor_res_t got);
            rfor_res_t want;
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("result %h with no request waiting", got));
            else
            begin
                want = expected_pixels.pop_front();
                if (got.pixel_char !== want.pixel_char)
                    report_mismatch($sformatf("pixel_char %h, want %h",
                                              got.pixel_char, want.pixel_char));
                if (got.error_flag !== want.error_flag)
                    report_mismatch($sformatf("error_flag %b, want %b",
                                              got.error_flag, want.error_flag));
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_stall;
    rfor_cmd_t        cmd_data;
    logic             res_valid;
    logic             res_stall;
    rfor_res_t        res_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    canvas_scoreboard canvas_track;
    int               hold_requests;
    bit               steady_stream;
    int               burst_left;
    int               cycle_count;

    rectangle_fill_outline_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic rfor_cmd_t plain_cmd(rfor_func_t f);
        rfor_cmd_t c;
        c      = '0;
        c.func = f;
        return c;
    endfunction

    function automatic rfor_cmd_t draw_cmd(logic [COORD_W-1:0] l, logic [COORD_W-1:0] t,
                                           logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
                                           logic [CHAR_W-1:0] shape,
                                           logic [CHAR_W-1:0] paint);
        rfor_cmd_t c;
        c              = '0;
        c.func         = FUNC_DRAW;
        c.rect_left    = l;
        c.rect_top     = t;
        c.rect_span_x  = w;
        c.rect_span_y  = h;
        c.shape_letter = shape;
        c.paint_char   = paint;
        return c;
    endfunction

    function automatic rfor_cmd_t read_cmd(logic [SIDE_W-1:0] col, logic [SIDE_W-1:0] row);
        rfor_cmd_t c;
        c          = '0;
        c.func     = FUNC_READ;
        c.read_col = col;
        c.read_row = row;
        return c;
    endfunction

    // Build a random request; most draws are well formed around the canvas
    function automatic rfor_cmd_t random_command(int cols, int rows);
        rfor_cmd_t c;
        int        pick;
        int        kind;
        c.func         = FUNC_NOP;
        c.rect_left    = COORD_W'($urandom());
        c.rect_top     = COORD_W'($urandom());
        c.rect_span_x  = COORD_W'($urandom());
        c.rect_span_y  = COORD_W'($urandom());
        c.shape_letter = CHAR_W'($urandom());
        c.paint_char   = CHAR_W'($urandom());
        c.read_col     = SIDE_W'($urandom());
        c.read_row     = SIDE_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 10)
            c.func = FUNC_CLEAR;
        else if (pick < 60)
        begin
            c.func = FUNC_DRAW;
            kind   = $urandom_range(0, 24);
            if (kind == 1)
            begin
                // break it: non-positive span or an unknown letter
                case ($urandom_range(0, 2))
                    0: c.rect_span_x = COORD_W'(-int'($urandom_range(0, 1024)));
                    1: c.rect_span_y = COORD_W'(-int'($urandom_range(0, 1024)));
                    default:
                    begin
                        c.rect_span_x = COORD_W'($urandom_range(1, 4 * ONE_FX));
                        c.rect_span_y = COORD_W'($urandom_range(1, 4 * ONE_FX));
                        if (c.shape_letter == SHAPE_FILLED || c.shape_letter == SHAPE_OUTLINE)
                            c.shape_letter = c.shape_letter ^ 8'h01;
                    end
                endcase
            end
            else if (kind != 0)
            begin
                c.shape_letter = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                c.rect_left    = COORD_W'(int'($urandom_range(0, (cols + 4) * ONE_FX))
                                          - 3 * ONE_FX);
                c.rect_top     = COORD_W'(int'($urandom_range(0, (rows + 4) * ONE_FX))
                                          - 3 * ONE_FX);
                c.rect_span_x  = COORD_W'($urandom_range(1, (cols + 3) * ONE_FX));
                c.rect_span_y  = COORD_W'($urandom_range(1, (rows + 3) * ONE_FX));
                // snap to whole units so edges land exactly on pixels
                if ($urandom_range(0, 3) == 0)
                begin
                    c.rect_left[FRAC_BITS-1:0] = '0;
                    c.rect_top[FRAC_BITS-1:0]  = '0;
                    c.rect_span_x = COORD_W'($urandom_range(1, cols + 3) * ONE_FX);
                    c.rect_span_y = COORD_W'($urandom_range(1, rows + 3) * ONE_FX);
                end
            end
        end
        else if (pick < 95)
        begin
            c.func = FUNC_READ;
            if ($urandom_range(0, 9) < 7)
            begin
                c.read_col = SIDE_W'($urandom_range(0, cols - 1));
                c.read_row = SIDE_W'($urandom_range(0, rows - 1));
            end
        end
        return c;
    endfunction

    // Offer one request, hold it until accepted, then maybe leave a gap
    task send_command(rfor_cmd_t c);
        int gap;
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        canvas_track.note_request(c);
        if (!steady_stream)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(0, 12);
                gap        = $urandom_range(1, 30);
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Stop offering and wait until every queued result has come back
    task drain();
        cmd_valid <= 1'b0;
        while (canvas_track.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Drain, then write width, height and background in one run
    task automatic configure_canvas(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                    logic [CFG_W-1:0] bg);
        rfor_cfg_idx_t    order [3];
        logic [CFG_W-1:0] values [3];
        order  = '{CFG_WIDTH, CFG_HEIGHT, CFG_BG};
        values = '{w, h, bg};
        drain();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= values[i];
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            canvas_track.set_register(order[i], values[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Receive side: check results and stall on a pattern of its own
    initial
    begin
        int         hold_left;
        int         hold_seen;
        int         mode_left;
        int         tick;
        flow_mode_t flow;
        res_stall = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        mode_left = 0;
        tick      = 0;
        flow      = FLOW_FREE;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
                canvas_track.check_result(res_data);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    flow      = flow_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                tick++;
                case (flow)
                    FLOW_FREE:  res_stall <= 1'b0;
                    FLOW_LIGHT: res_stall <= ($urandom_range(0, 9) < 3);
                    FLOW_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
                    default:    res_stall <= (tick % 5 < 3);
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rectangle_fill_outline_rasterizer_tb: errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        canvas_track  = new();
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_data      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_wdata     = '0;
        hold_requests = 0;
        steady_stream = 1'b0;
        burst_left    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-size clear first, so every pixel holds a known byte
        send_command(plain_cmd(FUNC_CLEAR));
        send_command(read_cmd(8'd255, 8'd255));
        send_command(plain_cmd(FUNC_NOP));

        // zero width and oversize height clamp to a 1 x 256 canvas
        configure_canvas(9'd0, 9'd511, 9'h1FF);
        send_command(plain_cmd(FUNC_CLEAR));
        send_command(read_cmd(8'd0, 8'd200));
        send_command(read_cmd(8'd1, 8'd0));

        // small canvas: fill, outline with fractional edges, errors
        configure_canvas(9'd12, 9'd10, 9'h02E);
        send_command(plain_cmd(FUNC_CLEAR));
        send_command(draw_cmd(24'h000280, 24'h000100, 24'h000600, 24'h000440,
                              SHAPE_FILLED, 8'h41));
        send_command(draw_cmd(24'hFFFF40, 24'h000000, 24'h000B00, 24'h000900,
                              SHAPE_OUTLINE, 8'h6F));
        send_command(read_cmd(8'd3, 8'd2));
        send_command(read_cmd(8'd8, 8'd5));
        send_command(read_cmd(8'd0, 8'd8));
        send_command(read_cmd(8'd12, 8'd3));
        send_command(draw_cmd(24'h000000, 24'h000000, 24'h000000, 24'h000100,
                              SHAPE_FILLED, 8'h23));
        send_command(draw_cmd(24'h000000, 24'h000000, 24'h000C00, 24'h000A00,
                              SHAPE_FILLED, 8'h23));
        send_command(read_cmd(8'd5, 8'd3));
        send_command(plain_cmd(FUNC_CLEAR));
        send_command(draw_cmd(24'h000000, 24'h000000, 24'h000100, 24'h000100,
                              8'h78, 8'h40));
        send_command(plain_cmd(FUNC_CLEAR));
        send_command(draw_cmd(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                              SHAPE_FILLED, 8'hFF));
        send_command(draw_cmd(24'h000000, 24'h000000, 24'h000100, 24'h800000,
                              SHAPE_OUTLINE, 8'h00));
        send_command(read_cmd(8'd0, 8'd0));

        // full canvas outline
        configure_canvas(9'd256, 9'd256, 9'h100);
        send_command(plain_cmd(FUNC_CLEAR));
        send_command(draw_cmd(24'h000000, 24'h000000, 24'h00FF00, 24'h00FF00,
                              SHAPE_OUTLINE, 8'h2A));
        send_command(read_cmd(8'd255, 8'd0));
        send_command(read_cmd(8'd128, 8'd128));

        // random phases, each under its own canvas setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                3:       configure_canvas(9'd0, 9'($urandom_range(257, 511)),
                                          9'($urandom()));
                4:       configure_canvas(9'($urandom_range(257, 511)),
                                          9'($urandom_range(1, 2)), 9'($urandom()));
                default: configure_canvas(9'($urandom_range(1, 16)),
                                          9'($urandom_range(1, 16)), 9'($urandom()));
            endcase
            // hold the receiver off while requests keep coming
            if (p == 1)
            begin
                hold_requests++;
                steady_stream = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 0 && i == PHASE_ITEMS / 2)
                    drain();
                send_command(random_command(canvas_track.canvas_cols(),
                                            canvas_track.canvas_rows()));
            end
            steady_stream = 1'b0;
        end

        drain();
        if (canvas_track.mismatches == 0 && canvas_track.pending() == 0)
            $display("rectangle_fill_outline_rasterizer_tb: clean");
        else
            $display("rectangle_fill_outline_rasterizer_tb: errors");
        $finish;
    end

endmodule
